// ----- design/dws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dws_pkg
// Shared types, constants and a helper function of the delta width selector.
// ----------------------------------------------------------------------------
package dws_pkg;

    localparam int DATA_W   = 64;
    localparam int VWIDTH_W = 7;
    localparam int HDR_W    = 8;

    localparam logic [VWIDTH_W-1:0] FULL_WIDTH  = 7'd64;
    localparam logic [VWIDTH_W-1:0] MIN_WIDTH   = 7'd1;
    localparam logic [VWIDTH_W-1:0] ZERO_WIDTH  = 7'd0;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_WIDTH   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPTIONAL_FLAG = 1'd1;
    localparam int CFG_DATA_W = 7;

    typedef enum logic {
        OP_BASE  = 1'b0,
        OP_VALUE = 1'b1
    } dws_opcode_t;

    typedef struct packed {
        logic              all_equal;
        logic [DATA_W-1:0] max_unsigned;
        logic [DATA_W-1:0] max_positive;
        logic [DATA_W-1:0] max_negative;
    } dws_summary_t;

    function automatic logic [VWIDTH_W-1:0] bit_length(input logic [DATA_W-1:0] x);
        logic [VWIDTH_W-1:0] n;
        n = ZERO_WIDTH;
        for (int i = 0; i < DATA_W; i++)
        begin
            if (x[i])
            begin
                n = VWIDTH_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- design/dws_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dws_item_if / dws_result_if
// Valid/ready channels for input items and for width selection results.
// ----------------------------------------------------------------------------
interface dws_item_if
    import dws_pkg::*;
();
    logic                valid;
    logic                ready;
    dws_opcode_t         opcode;
    logic [DATA_W-1:0]   data;
    logic                last;

    modport source (output valid, output opcode, output data, output last, input ready);
    modport sink   (input valid, input opcode, input data, input last, output ready);
endinterface

interface dws_result_if
    import dws_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [VWIDTH_W-1:0] delta_width;
    logic                signed_mode;
    logic [HDR_W-1:0]    header;

    modport source (output valid, output delta_width, output signed_mode, output header,
                    input ready);
    modport sink   (input valid, input delta_width, input signed_mode, input header,
                    output ready);
endinterface
`default_nettype wire

// ----- design/dws_delta_track.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dws_delta_track
// Batch state: previous value, base value, the three delta maxima and the
// all-equal flag, updated once per consumed item.
// ----------------------------------------------------------------------------
module dws_delta_track
    import dws_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                upd_en,
    input  wire dws_opcode_t         opcode,
    input  wire logic [DATA_W-1:0]   data,
    input  wire logic                last,
    input  wire logic [VWIDTH_W-1:0] value_width,
    output dws_summary_t             summary
);

    logic [DATA_W-1:0] prev_reg, prev_next;
    logic [DATA_W-1:0] base_reg, base_next;
    dws_summary_t      acc_reg, acc_next;

    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] fwd;
    logic [DATA_W-1:0] bwd;
    dws_summary_t      upd;

    always_comb
    begin
        if (value_width >= FULL_WIDTH)
        begin
            mask = '1;
        end
        else if (value_width == ZERO_WIDTH)
        begin
            mask = DATA_W'(1);
        end
        else
        begin
            mask = (DATA_W'(1) << value_width[5:0]) - DATA_W'(1);
        end
        fwd = (data - prev_reg) & mask;
        bwd = (prev_reg - data) & mask;
    end

    always_comb
    begin
        upd       = acc_reg;
        base_next = base_reg;
        unique case (opcode)
            OP_BASE:
            begin
                base_next = data;
                upd       = '{all_equal: 1'b1, default: '0};
            end
            OP_VALUE:
            begin
                if (fwd > acc_reg.max_unsigned)
                begin
                    upd.max_unsigned = fwd;
                end
                if (fwd < bwd)
                begin
                    if (fwd > acc_reg.max_positive)
                    begin
                        upd.max_positive = fwd;
                    end
                end
                else if (bwd > acc_reg.max_negative)
                begin
                    upd.max_negative = bwd;
                end
                upd.all_equal = acc_reg.all_equal & (data == base_reg);
            end
            default:
            begin
                upd = acc_reg;
            end
        endcase
        summary = upd;
    end

    always_comb
    begin
        prev_next = prev_reg;
        acc_next  = acc_reg;
        if (upd_en)
        begin
            if (last)
            begin
                prev_next = base_next;
                acc_next  = '{all_equal: 1'b1, default: '0};
            end
            else
            begin
                prev_next = (opcode == OP_BASE) ? base_next : data;
                acc_next  = upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            base_reg <= '0;
            acc_reg  <= '{all_equal: 1'b1, default: '0};
        end
        else if (upd_en)
        begin
            prev_reg <= prev_next;
            base_reg <= base_next;
            acc_reg  <= acc_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/dws_width_pick.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dws_width_pick
// Holds the batch summary of a finished batch, picks the delta width and
// signedness from it and presents the result in an output register.
// ----------------------------------------------------------------------------
module dws_width_pick
    import dws_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire dws_summary_t summary_in,
    input  wire logic         optional_flag,
    output logic              free,
    dws_result_if.source      result
);

    logic                sum_valid_reg, sum_valid_next;
    dws_summary_t        sum_reg;
    logic                out_valid_reg, out_valid_next;
    logic [VWIDTH_W-1:0] width_reg;
    logic                sgn_reg;
    logic [HDR_W-1:0]    header_reg;

    logic                out_take;
    logic [VWIDTH_W-1:0] wu;
    logic [VWIDTH_W-1:0] wp;
    logic [VWIDTH_W-1:0] wn;
    logic [VWIDTH_W-1:0] ws;
    logic [VWIDTH_W-1:0] width_sel;
    logic                sgn_sel;
    logic [VWIDTH_W-1:0] width_m1;

    assign out_take = !out_valid_reg || result.ready;
    assign free     = !sum_valid_reg || out_take;

    always_comb
    begin
        wu = bit_length(sum_reg.max_unsigned);
        if (wu == ZERO_WIDTH)
        begin
            wu = MIN_WIDTH;
        end
        wp = bit_length(sum_reg.max_positive);
        wn = (sum_reg.max_negative == '0) ? ZERO_WIDTH
                                          : bit_length(sum_reg.max_negative - DATA_W'(1));
        ws = MIN_WIDTH + ((wp > wn) ? wp : wn);
        if (sum_reg.all_equal)
        begin
            width_sel = FULL_WIDTH;
            sgn_sel   = 1'b1;
        end
        else
        begin
            sgn_sel   = ws < wu;
            width_sel = sgn_sel ? ws : wu;
        end
        width_m1 = width_sel - MIN_WIDTH;
    end

    always_comb
    begin
        sum_valid_next = load || (sum_valid_reg && !out_take);
        out_valid_next = out_take ? sum_valid_reg : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= summary_in;
        end
        if (out_take && sum_valid_reg)
        begin
            width_reg  <= width_sel;
            sgn_reg    <= sgn_sel;
            header_reg <= {optional_flag, sgn_sel, width_m1[5:0]};
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.delta_width = width_reg;
    assign result.signed_mode = sgn_reg;
    assign result.header      = header_reg;

endmodule
`default_nettype wire

// ----- design/delta_width_selector_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// delta_width_selector_core
// Selects the delta encoding width and signedness of a batch of values.
// ----------------------------------------------------------------------------
// An item is taken into an input register and updates the batch maxima as it
// leaves it; a new item can be transferred in every cycle. A base item opens a
// batch and an item marked last closes it and yields one result: the batch
// summary is snapshot into a summary register, then the width is picked into
// the output register. Results queue in these two stages, so a stalled result
// port holds off new items only once both are full and a last item waits. The
// register writes to value_width and optional_flag take effect at once and are
// meant for idle periods between batches.
// ----------------------------------------------------------------------------
module delta_width_selector_core
    import dws_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    dws_item_if.sink                   item,
    dws_result_if.source               result,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [VWIDTH_W-1:0] vwidth_reg;
    logic                optional_reg;

    logic                a_valid_reg, a_valid_next;
    dws_opcode_t         a_opcode_reg;
    logic [DATA_W-1:0]   a_data_reg;
    logic                a_last_reg;

    logic                a_consume;
    logic                pick_free;
    logic                item_xfer;
    dws_summary_t        summary;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vwidth_reg   <= FULL_WIDTH;
            optional_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VALUE_WIDTH:
                begin
                    vwidth_reg <= cfg_data[VWIDTH_W-1:0];
                end
                CFG_OPTIONAL_FLAG:
                begin
                    optional_reg <= cfg_data[0];
                end
                default:
                begin
                    optional_reg <= optional_reg;
                end
            endcase
        end
    end

    assign a_consume  = a_valid_reg && (!a_last_reg || pick_free);
    assign item.ready = !a_valid_reg || a_consume;
    assign item_xfer  = item.valid && item.ready;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (item_xfer)
        begin
            a_valid_next = 1'b1;
        end
        else if (a_consume)
        begin
            a_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer)
        begin
            a_opcode_reg <= item.opcode;
            a_data_reg   <= item.data;
            a_last_reg   <= item.last;
        end
    end

    dws_delta_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd_en      (a_consume),
        .opcode      (a_opcode_reg),
        .data        (a_data_reg),
        .last        (a_last_reg),
        .value_width (vwidth_reg),
        .summary     (summary)
    );

    dws_width_pick u_pick (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (a_consume && a_last_reg),
        .summary_in    (summary),
        .optional_flag (optional_reg),
        .free          (pick_free),
        .result        (result)
    );

endmodule
`default_nettype wire

// ----- design/dws_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dws_checker
// Port-level checks on the result channel of the delta width selector.
// ----------------------------------------------------------------------------
module dws_checker
    import dws_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                out_valid,
    input  wire logic                out_ready,
    input  wire logic [VWIDTH_W-1:0] out_width,
    input  wire logic                out_signed,
    input  wire logic [HDR_W-1:0]    out_header
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_width)
                                    && $stable(out_signed) && $stable(out_header))
        else $error("Result changed while stalled.");

    a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_width != ZERO_WIDTH) && (out_width <= FULL_WIDTH))
        else $error("Delta width out of range.");

    a_header_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_header[5:0] == 6'(out_width - MIN_WIDTH))
        else $error("Header width field does not match delta width.");

    a_header_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_header[6] == out_signed)
        else $error("Header sign bit does not match signed mode.");

endmodule

bind delta_width_selector_core dws_checker u_dws_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_width  (result.delta_width),
    .out_signed (result.signed_mode),
    .out_header (result.header)
);
`default_nettype wire

// ----- tb/tb_delta_width_selector_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_delta_width_selector_core
// Self-checking bench for the delta width selector core. A driver replays
// queued batch items in random bursts. A monitor compares every result
// transfer against the width, signedness and header predicted from the accepted
// items. Several value width and optional flag settings are exercised.
// ----------------------------------------------------------------------------
module tb_delta_width_selector_core;
    import dws_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1700;
    localparam int unsigned NUM_PHASES    = 8;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_STALL    = 400;
    localparam int unsigned IDLE_LIMIT    = 4000;
    localparam int unsigned MAX_REPORTS   = 40;
    localparam int unsigned HDR_SIGNED    = 64;
    localparam int unsigned HDR_OPTIONAL  = 128;

    localparam int unsigned PHASE_WIDTH [NUM_PHASES] = '{1, 0, 8, 100, 33, 64, 63, 2};
    localparam bit          PHASE_OPT   [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0,
                                                         1'b1, 1'b0, 1'b1, 1'b0};

    typedef struct {
        dws_opcode_t       opcode;
        logic [DATA_W-1:0] data;
        logic              last;
    } batch_item_t;

    typedef struct packed {
        logic [VWIDTH_W-1:0] delta_width;
        logic                signed_mode;
        logic [HDR_W-1:0]    header;
    } width_choice_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dws_item_if   item_ch ();
    dws_result_if result_ch ();

    delta_width_selector_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    batch_item_t   pending_items[$];
    width_choice_t expected_choices[$];

    logic [VWIDTH_W-1:0] cfg_vwidth   = FULL_WIDTH;
    logic                cfg_optional = 1'b0;

    logic [DATA_W-1:0] batch_base  = '0;
    logic [DATA_W-1:0] batch_prev  = '0;
    logic [DATA_W-1:0] max_fwd     = '0;
    logic [DATA_W-1:0] max_pos     = '0;
    logic [DATA_W-1:0] max_neg     = '0;
    logic              all_at_base = 1'b1;

    int unsigned items_accepted   = 0;
    int unsigned results_checked  = 0;
    int unsigned mismatches       = 0;
    int unsigned idle_cycles      = 0;
    int unsigned burst_left       = 1;
    int unsigned gap_left         = 0;
    int unsigned rx_mode          = 0;
    int unsigned rx_mode_left     = 0;
    int unsigned rx_count         = 0;
    int unsigned stall_left       = 0;
    int unsigned long_stall_req   = 0;
    int unsigned long_stall_seen  = 0;
    int unsigned items_queued     = 0;

    function automatic int unsigned significant_bits(logic [DATA_W-1:0] x);
        int unsigned n;
        n = 0;
        while (x != '0)
        begin
            n++;
            x = x >> 1;
        end
        return n;
    endfunction

    function automatic void restart_batch();
        batch_prev  = batch_base;
        max_fwd     = '0;
        max_pos     = '0;
        max_neg     = '0;
        all_at_base = 1'b1;
    endfunction

    function automatic void predict_item(dws_opcode_t op, logic [DATA_W-1:0] value,
                                         logic is_last);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] fwd;
        logic [DATA_W-1:0] bwd;
        int unsigned       w;
        int unsigned       wu;
        int unsigned       wp;
        int unsigned       wn;
        int unsigned       ws;
        logic              sgn;
        width_choice_t     choice;
        if (op == OP_BASE)
        begin
            batch_base = value;
            restart_batch();
        end
        else
        begin
            w    = (cfg_vwidth == ZERO_WIDTH) ? 1 : cfg_vwidth;
            mask = (w >= DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
            fwd  = (value - batch_prev) & mask;
            bwd  = (batch_prev - value) & mask;
            if (fwd > max_fwd)
            begin
                max_fwd = fwd;
            end
            if (fwd < bwd)
            begin
                if (fwd > max_pos)
                begin
                    max_pos = fwd;
                end
            end
            else if (bwd > max_neg)
            begin
                max_neg = bwd;
            end
            if (value != batch_base)
            begin
                all_at_base = 1'b0;
            end
            batch_prev = value;
        end
        if (is_last)
        begin
            if (all_at_base)
            begin
                w   = DATA_W;
                sgn = 1'b1;
            end
            else
            begin
                wu  = significant_bits(max_fwd);
                wp  = significant_bits(max_pos);
                wn  = (max_neg == '0) ? 0 : significant_bits(max_neg - 64'd1);
                wu  = (wu == 0) ? 1 : wu;
                ws  = 1 + ((wp > wn) ? wp : wn);
                sgn = (ws < wu);
                w   = sgn ? ws : wu;
            end
            choice.delta_width = VWIDTH_W'(w);
            choice.signed_mode = sgn;
            choice.header      = HDR_W'((w - 1) + (sgn ? HDR_SIGNED : 0)
                                        + (cfg_optional ? HDR_OPTIONAL : 0));
            expected_choices.push_back(choice);
            restart_batch();
        end
    endfunction

    function automatic logic [DATA_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    function automatic void queue_item(dws_opcode_t op, logic [DATA_W-1:0] value,
                                       logic is_last);
        batch_item_t it;
        it.opcode = op;
        it.data   = value;
        it.last   = is_last;
        pending_items.push_back(it);
        items_queued++;
    endfunction

    // Mostly well-formed batches with deltas of random magnitude; some noise and
    // some batches that run on past their last item without a new base.
    function automatic void queue_random_batch();
        logic [DATA_W-1:0] base_word;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] jump;
        int unsigned       n;
        int unsigned       k;
        int unsigned       flavor;
        flavor = $urandom_range(0, 9);
        if (flavor == 0)
        begin
            queue_item(dws_opcode_t'($urandom_range(0, 1)), random_word(),
                       1'($urandom_range(0, 1)));
            return;
        end
        base_word = random_word();
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 10);
        queue_item(OP_BASE, base_word, n == 0);
        value = base_word;
        for (int i = 0; i < n + ((flavor == 1) ? $urandom_range(1, 3) : 0); i++)
        begin
            case ($urandom_range(0, 7))
                0: value = base_word;
                1: value = random_word();
                2: value = ($urandom_range(0, 1) != 0) ? '1 : {1'b1, 63'd0};
                default:
                begin
                    k    = $urandom_range(0, DATA_W);
                    jump = (k == DATA_W) ? random_word()
                                         : (random_word() & ((64'd1 << k) - 64'd1));
                    value = ($urandom_range(0, 1) != 0) ? value + jump : value - jump;
                end
            endcase
            queue_item(OP_VALUE, value, (i == n - 1) || ($urandom_range(0, 30) == 0));
        end
        if (flavor == 1 && n != 0)
        begin
            queue_item(OP_VALUE, random_word(), 1'b1);
        end
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_VALUE_WIDTH:   cfg_vwidth   = VWIDTH_W'(val);
            CFG_OPTIONAL_FLAG: cfg_optional = val[0];
            default:           ;
        endcase
    endtask

    task automatic wait_drained(int unsigned settle);
        while (pending_items.size() != 0 || item_ch.valid || expected_choices.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (settle) @(posedge clk);
    endtask

    function automatic void report_mismatch(string field, int unsigned want,
                                            int unsigned got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid  <= 1'b0;
            item_ch.opcode <= OP_BASE;
            item_ch.data   <= '0;
            item_ch.last   <= 1'b0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predict_item(item_ch.opcode, item_ch.data, item_ch.last);
                void'(pending_items.pop_front());
                items_accepted++;
            end
            if (item_ch.valid && !item_ch.ready)
            begin
                item_ch.valid <= 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                item_ch.valid <= 1'b0;
            end
            else if (pending_items.size() == 0)
            begin
                item_ch.valid <= 1'b0;
            end
            else
            begin
                item_ch.valid  <= 1'b1;
                item_ch.opcode <= pending_items[0].opcode;
                item_ch.data   <= pending_items[0].data;
                item_ch.last   <= pending_items[0].last;
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else
        begin
            if (long_stall_req != long_stall_seen)
            begin
                long_stall_seen = long_stall_req;
                stall_left      = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_mode_left == 0)
                begin
                    rx_mode      = $urandom_range(0, 3);
                    rx_mode_left = $urandom_range(20, 200);
                end
                rx_mode_left--;
                rx_count++;
                case (rx_mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: result_ch.ready <= ((rx_count % 5) < 2);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_choices.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: result transfer with nothing expected, actual width %0d",
                         $time, result_ch.delta_width);
            end
            else
            begin
                if (result_ch.delta_width !== expected_choices[0].delta_width)
                begin
                    report_mismatch("delta_width", expected_choices[0].delta_width,
                                    result_ch.delta_width);
                end
                if (result_ch.signed_mode !== expected_choices[0].signed_mode)
                begin
                    report_mismatch("signed_mode", expected_choices[0].signed_mode,
                                    result_ch.signed_mode);
                end
                if (result_ch.header !== expected_choices[0].header)
                begin
                    report_mismatch("header", expected_choices[0].header, result_ch.header);
                end
                void'(expected_choices.pop_front());
                results_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_VALUE_WIDTH;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.opcode  = OP_BASE;
        item_ch.data    = '0;
        item_ch.last    = 1'b0;
        result_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed batches at the reset settings.
        queue_item(OP_VALUE, 64'd5, 1'b0);
        queue_item(OP_VALUE, 64'd3, 1'b1);
        queue_item(OP_VALUE, 64'd7, 1'b1);
        queue_item(OP_BASE, 64'd123, 1'b1);
        queue_item(OP_BASE, '1, 1'b0);
        queue_item(OP_VALUE, '1, 1'b0);
        queue_item(OP_VALUE, '1, 1'b1);
        queue_item(OP_BASE, '0, 1'b0);
        queue_item(OP_VALUE, '1, 1'b1);
        queue_item(OP_BASE, '0, 1'b0);
        queue_item(OP_VALUE, {1'b1, 63'd0}, 1'b1);
        queue_item(OP_BASE, 64'd10, 1'b0);
        queue_item(OP_VALUE, 64'd20, 1'b0);
        queue_item(OP_VALUE, 64'd10, 1'b1);
        queue_item(OP_BASE, {1'b1, 63'd0}, 1'b0);
        queue_item(OP_VALUE, {1'b1, 63'd1}, 1'b0);
        queue_item(OP_VALUE, {1'b0, {63{1'b1}}}, 1'b1);
        queue_item(OP_BASE, '1, 1'b0);
        queue_item(OP_VALUE, '0, 1'b1);
        queue_item(OP_BASE, 64'h0123_4567_89ab_cdef, 1'b0);
        queue_item(OP_VALUE, 64'hfedc_ba98_7654_3210, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained(SETTLE_CYCLES);
            write_reg(CFG_VALUE_WIDTH, (p == NUM_PHASES - 1) ? $urandom_range(1, 64)
                                                             : PHASE_WIDTH[p]);
            write_reg(CFG_OPTIONAL_FLAG, (p == NUM_PHASES - 1) ? $urandom_range(0, 1)
                                                               : PHASE_OPT[p]);
            items_queued = 0;
            while (items_queued < RANDOM_ITEMS / NUM_PHASES / 2)
            begin
                queue_random_batch();
            end
            if (p % 3 == 1)
            begin
                long_stall_req++;
            end
            if (p % 3 == 2)
            begin
                wait_drained(0);
            end
            while (items_queued < RANDOM_ITEMS / NUM_PHASES)
            begin
                queue_random_batch();
            end
        end

        wait_drained(SETTLE_CYCLES);
        $display("Covered %0d item transfers and %0d checked results over %0d settings,",
                 items_accepted, results_checked, NUM_PHASES + 1);
        $display("with value widths from 0 to 100 and both optional flag values.");
        if (mismatches == 0 && expected_choices.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/dws_pkg.sv
design/dws_if.sv
design/dws_delta_track.sv
design/dws_width_pick.sv
design/delta_width_selector_core.sv
design/dws_checker.sv
tb/tb_delta_width_selector_core.sv
